/* design/ccx_pkg.sv */
// Shared widths and payload types of the circle intersection pipeline.
package ccx_pkg;

	// Coordinate width of the ports.
	localparam int CW = 32;
	// Radius width.
	localparam int RW = CW - 1;
	// Magnitude width of a centre difference.
	localparam int VM = CW + 1;
	// Width of the squared centre distance.
	localparam int VVW = 2 * VM + 1;
	// Magnitude width of n = R1^2 - R2^2 + vv.
	localparam int NMW = VVW + 1;
	// Square root operand width, rounded up to an even count.
	localparam int SQW = ((2 * RW + VVW + 3) / 2) * 2;
	// Square root result width.
	localparam int SW = SQW / 2;
	// Width of one product of the last multiplier group.
	localparam int PW = NMW + VM;
	// Magnitude width of a divider numerator.
	localparam int NW = PW + 1;
	// Divisor width (twice the squared distance).
	localparam int DVW = VVW + 1;

	typedef struct packed {
		logic signed [CW-1:0] first_center_x;
		logic signed [CW-1:0] first_center_y;
		logic        [RW-1:0] first_radius;
		logic signed [CW-1:0] second_center_x;
		logic signed [CW-1:0] second_center_y;
		logic        [RW-1:0] second_radius;
	} item_t;

	typedef struct packed {
		logic                 touching;
		logic                 fully_contained;
		logic                 coincident;
		logic signed [CW-1:0] point1_x;
		logic signed [CW-1:0] point1_y;
		logic signed [CW-1:0] point2_x;
		logic signed [CW-1:0] point2_y;
	} result_t;

endpackage

/* design/circle_circle_intersection.sv */
// Throughput: one item per cycle; the whole pipeline advances together unless a
// finished result is held by result_stall.
// The deepest units are the 66-stage square root and the 103-stage dividers
// (102 quotient bits and the rounding register).
// Reset (arst_n low) clears every valid bit at once; data registers are not reset.
// Top level of the circle-circle intersection pipeline.
module circle_circle_intersection #(
	parameter int MUL_DIGIT = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  ccx_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output ccx_pkg::result_t result
);

	import ccx_pkg::*;

	// Stage counts of the two multiplier widths used below.
	localparam int ND1 = (VM + MUL_DIGIT - 1) / MUL_DIGIT;
	localparam int ND2 = (NMW + MUL_DIGIT - 1) / MUL_DIGIT;
	// Total latency: four single stage registers, three multiplier groups, root,
	// divider with its rounding register, output.
	localparam int LAT = 6 + 2 * ND1 + ND2 + SW + NW;

	// Data that travels beside the first multiplier group.
	typedef struct packed {
		logic signed [CW-1:0] x1;
		logic signed [CW-1:0] y1;
		logic                 sx;
		logic                 sy;
		logic [VM-1:0]        vxm;
		logic [VM-1:0]        vym;
	} side1_t;

	// Data that travels from the distance stage to the output.
	typedef struct packed {
		logic signed [CW-1:0] x1;
		logic signed [CW-1:0] y1;
		logic                 sx;
		logic                 sy;
		logic [VM-1:0]        vxm;
		logic [VM-1:0]        vym;
		logic                 sn;
		logic [NMW-1:0]       nm;
		logic [VVW-1:0]       vv;
		logic                 cont;
		logic                 nocon;
		logic                 zero;
	} side2_t;

	// Two's complement of a sign and magnitude product.
	function automatic logic signed [PW+1:0] tcv(input logic [PW-1:0] m, input logic ng);
		logic signed [PW+1:0] v;
		v = $signed({2'b00, m});
		return ng ? -v : v;
	endfunction

	// Clamp the offset, add it to the centre coordinate and saturate.
	function automatic logic [CW-1:0] place(input logic signed [CW-1:0] base,
		input logic [NW:0] qm, input logic ng);
		logic [CW:0]          qc;
		logic signed [CW+2:0] off;
		logic signed [CW+2:0] sum;
		logic [3:0]           top;
		logic [CW-1:0]        res;
		qc = (|qm[NW:CW+1]) ? {1'b1, {CW{1'b0}}} : qm[CW:0];
		off = ng ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
		sum = $signed({{3{base[CW-1]}}, base}) + off;
		top = sum[CW+2:CW-1];
		if (top == 4'b0000 || top == 4'b1111) begin
			res = sum[CW-1:0];
		end else if (sum[CW+2]) begin
			res = {1'b1, {(CW-1){1'b0}}};
		end else begin
			res = {1'b0, {(CW-1){1'b1}}};
		end
		return res;
	endfunction

	// The pipeline advances whenever the output register is free or being taken.
	logic           en;
	logic [LAT-1:0] vld_q;

	assign en = !result_valid || !result_stall;
	assign item_stall = !en;
	assign result_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], item_valid};
		end
	end

	// Stage 1: centre differences and radius sum and difference.
	logic signed [VM-1:0] vx_c;
	logic signed [VM-1:0] vy_c;
	logic [RW-1:0]        dr_c;
	logic [CW-1:0]        rs_c;
	side1_t               side1_s1;
	logic [VM-1:0]        r1_s1;
	logic [VM-1:0]        r2_s1;
	logic [VM-1:0]        dr_s1;
	logic [VM-1:0]        rs_s1;

	always_comb begin
		vx_c = $signed({item.second_center_x[CW-1], item.second_center_x})
			- $signed({item.first_center_x[CW-1], item.first_center_x});
		vy_c = $signed({item.second_center_y[CW-1], item.second_center_y})
			- $signed({item.first_center_y[CW-1], item.first_center_y});
		dr_c = (item.first_radius >= item.second_radius)
			? item.first_radius - item.second_radius
			: item.second_radius - item.first_radius;
		rs_c = {1'b0, item.first_radius} + {1'b0, item.second_radius};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side1_s1.x1 <= item.first_center_x;
			side1_s1.y1 <= item.first_center_y;
			side1_s1.sx <= vx_c[VM-1];
			side1_s1.sy <= vy_c[VM-1];
			side1_s1.vxm <= vx_c[VM-1] ? -vx_c : vx_c;
			side1_s1.vym <= vy_c[VM-1] ? -vy_c : vy_c;
			r1_s1 <= VM'(item.first_radius);
			r2_s1 <= VM'(item.second_radius);
			dr_s1 <= VM'(dr_c);
			rs_s1 <= VM'(rs_c);
		end
	end

	// First multiplier group: the six squares.
	logic [2*VM-1:0] vxx_c;
	logic [2*VM-1:0] vyy_c;
	logic [2*VM-1:0] r1sq_c;
	logic [2*VM-1:0] r2sq_c;
	logic [2*VM-1:0] drsq_c;
	logic [2*VM-1:0] rssq_c;
	side1_t          side1_d;

	ccx_mul #(.AW(VM), .BW(VM), .DW(MUL_DIGIT)) u_mul_vxx (
		.clk(clk), .en(en), .a(side1_s1.vxm), .b(side1_s1.vxm), .p(vxx_c));
	ccx_mul #(.AW(VM), .BW(VM), .DW(MUL_DIGIT)) u_mul_vyy (
		.clk(clk), .en(en), .a(side1_s1.vym), .b(side1_s1.vym), .p(vyy_c));
	ccx_mul #(.AW(VM), .BW(VM), .DW(MUL_DIGIT)) u_mul_r1 (
		.clk(clk), .en(en), .a(r1_s1), .b(r1_s1), .p(r1sq_c));
	ccx_mul #(.AW(VM), .BW(VM), .DW(MUL_DIGIT)) u_mul_r2 (
		.clk(clk), .en(en), .a(r2_s1), .b(r2_s1), .p(r2sq_c));
	ccx_mul #(.AW(VM), .BW(VM), .DW(MUL_DIGIT)) u_mul_dr (
		.clk(clk), .en(en), .a(dr_s1), .b(dr_s1), .p(drsq_c));
	ccx_mul #(.AW(VM), .BW(VM), .DW(MUL_DIGIT)) u_mul_rs (
		.clk(clk), .en(en), .a(rs_s1), .b(rs_s1), .p(rssq_c));

	ccx_dly #(.W($bits(side1_t)), .N(ND1)) u_dly_1 (
		.clk(clk), .en(en), .d(side1_s1), .q(side1_d));

	// Stage 2: squared distance, the three classification compares and n.
	logic [VVW-1:0] vv_c;
	logic [NMW:0]   n_c;
	logic [NMW:0]   nneg_c;
	side2_t         side2_s2;
	logic [NMW-1:0] r1sq_s2;

	always_comb begin
		vv_c = VVW'(vxx_c) + VVW'(vyy_c);
		n_c = (NMW+1)'(r1sq_c) - (NMW+1)'(r2sq_c) + (NMW+1)'(vv_c);
		nneg_c = -n_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side2_s2.x1 <= side1_d.x1;
			side2_s2.y1 <= side1_d.y1;
			side2_s2.sx <= side1_d.sx;
			side2_s2.sy <= side1_d.sy;
			side2_s2.vxm <= side1_d.vxm;
			side2_s2.vym <= side1_d.vym;
			side2_s2.sn <= n_c[NMW];
			side2_s2.nm <= n_c[NMW] ? nneg_c[NMW-1:0] : n_c[NMW-1:0];
			side2_s2.vv <= vv_c;
			side2_s2.cont <= vv_c < VVW'(drsq_c);
			side2_s2.nocon <= vv_c > VVW'(rssq_c);
			side2_s2.zero <= vv_c == '0;
			r1sq_s2 <= NMW'(r1sq_c);
		end
	end

	// Second multiplier group: R1^2 * vv and n^2.
	logic [VVW+NMW-1:0] p_c;
	logic [2*NMW-1:0]   nn_c;
	side2_t             side2_d;

	ccx_mul #(.AW(VVW), .BW(NMW), .DW(MUL_DIGIT)) u_mul_p (
		.clk(clk), .en(en), .a(side2_s2.vv), .b(r1sq_s2), .p(p_c));
	ccx_mul #(.AW(NMW), .BW(NMW), .DW(MUL_DIGIT)) u_mul_nn (
		.clk(clk), .en(en), .a(side2_s2.nm), .b(side2_s2.nm), .p(nn_c));

	ccx_dly #(.W($bits(side2_t)), .N(ND2)) u_dly_2 (
		.clk(clk), .en(en), .d(side2_s2), .q(side2_d));

	// Stage 3: square root argument 4*R1^2*vv - n^2, clamped at zero.
	logic [2*NMW+1:0] p4_c;
	logic [2*NMW+1:0] nnx_c;
	logic [2*NMW+1:0] qd_c;
	logic [SQW-1:0]   q_s3;
	side2_t           side_s3;

	always_comb begin
		p4_c = (2*NMW+2)'({p_c, 2'b00});
		nnx_c = (2*NMW+2)'(nn_c);
		qd_c = (p4_c > nnx_c) ? p4_c - nnx_c : '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s3 <= qd_c[SQW-1:0];
			side_s3 <= side2_d;
		end
	end

	// Square root.
	logic [SW-1:0] s_c;
	side2_t        side_t;

	ccx_sqrt #(.XW(SQW)) u_sqrt (
		.clk(clk), .en(en), .x(q_s3), .root(s_c));

	ccx_dly #(.W($bits(side2_t)), .N(SW)) u_dly_3 (
		.clk(clk), .en(en), .d(side_s3), .q(side_t));

	// Third multiplier group: the four products v*n and v*s.
	logic [PW-1:0] ax_c;
	logic [PW-1:0] ay_c;
	logic [PW-1:0] bx_c;
	logic [PW-1:0] by_c;
	side2_t        side_g;

	ccx_mul #(.AW(NMW), .BW(VM), .DW(MUL_DIGIT)) u_mul_ax (
		.clk(clk), .en(en), .a(side_t.nm), .b(side_t.vxm), .p(ax_c));
	ccx_mul #(.AW(NMW), .BW(VM), .DW(MUL_DIGIT)) u_mul_ay (
		.clk(clk), .en(en), .a(side_t.nm), .b(side_t.vym), .p(ay_c));
	ccx_mul #(.AW(NMW), .BW(VM), .DW(MUL_DIGIT)) u_mul_bx (
		.clk(clk), .en(en), .a(NMW'(s_c)), .b(side_t.vxm), .p(bx_c));
	ccx_mul #(.AW(NMW), .BW(VM), .DW(MUL_DIGIT)) u_mul_by (
		.clk(clk), .en(en), .a(NMW'(s_c)), .b(side_t.vym), .p(by_c));

	ccx_dly #(.W($bits(side2_t)), .N(ND1)) u_dly_4 (
		.clk(clk), .en(en), .d(side_t), .q(side_g));

	// Stage 4: the four numerators, split into sign and magnitude.
	// Order: point1 x, point1 y, point2 x, point2 y.
	logic signed [PW+1:0] num_c [4];
	logic [PW+1:0]        abs_c [4];
	logic [NW-1:0]        mag_s4 [4];
	logic [3:0]           neg_s4;
	side2_t               side_s4;

	always_comb begin
		num_c[0] = tcv(ax_c, side_g.sx ^ side_g.sn) - tcv(by_c, side_g.sy);
		num_c[1] = tcv(ay_c, side_g.sy ^ side_g.sn) + tcv(bx_c, side_g.sx);
		num_c[2] = tcv(ax_c, side_g.sx ^ side_g.sn) + tcv(by_c, side_g.sy);
		num_c[3] = tcv(ay_c, side_g.sy ^ side_g.sn) - tcv(bx_c, side_g.sx);
		for (int i = 0; i < 4; i++) begin
			abs_c[i] = num_c[i][PW+1] ? -num_c[i] : num_c[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				mag_s4[i] <= abs_c[i][NW-1:0];
				neg_s4[i] <= num_c[i][PW+1];
			end
			side_s4 <= side_g;
		end
	end

	// Four dividers by 2*vv; a zero divisor only occurs where the points are masked.
	logic [NW:0] quo_c [4];
	side2_t      side_o;
	logic [3:0]  neg_o;

	for (genvar i = 0; i < 4; i++) begin : g_div
		ccx_div #(.NW(NW), .DVW(DVW)) u_div (
			.clk(clk), .en(en), .num(mag_s4[i]), .den({side_s4.vv, 1'b0}),
			.quo(quo_c[i]));
	end

	ccx_dly #(.W($bits(side2_t)), .N(NW + 1)) u_dly_5 (
		.clk(clk), .en(en), .d(side_s4), .q(side_o));
	ccx_dly #(.W(4), .N(NW + 1)) u_dly_6 (
		.clk(clk), .en(en), .d(neg_s4), .q(neg_o));

	// Output stage: classification has priority containment, no contact,
	// coincident circles, then the two points.
	result_t res_c;
	result_t res_q;

	always_comb begin
		res_c = '0;
		if (side_o.cont) begin
			res_c.touching = 1'b1;
			res_c.fully_contained = 1'b1;
		end else if (side_o.nocon) begin
			res_c = '0;
		end else if (side_o.zero) begin
			res_c.touching = 1'b1;
			res_c.coincident = 1'b1;
		end else begin
			res_c.touching = 1'b1;
			res_c.point1_x = place(side_o.x1, quo_c[0], neg_o[0]);
			res_c.point1_y = place(side_o.y1, quo_c[1], neg_o[1]);
			res_c.point2_x = place(side_o.x1, quo_c[2], neg_o[2]);
			res_c.point2_y = place(side_o.y1, quo_c[3], neg_o[3]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_c;
		end
	end

	assign result = res_q;

endmodule

/* design/ccx_dly.sv */
// Delay line with a shared advance enable, for data riding beside a pipelined unit.
module ccx_dly #(
	parameter int W = 8,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] sr_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			sr_q[0] <= d;
			for (int k = 1; k < N; k++) begin
				sr_q[k] <= sr_q[k-1];
			end
		end
	end

	assign q = sr_q[N-1];

endmodule

/* design/ccx_mul.sv */
// Pipelined unsigned multiplier that takes one digit of b per stage.
module ccx_mul #(
	parameter int AW = 8,
	parameter int BW = 8,
	parameter int DW = 16
) (
	input  logic             clk,
	input  logic             en,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic [AW+BW-1:0] p
);

	localparam int ND = (BW + DW - 1) / DW;
	localparam int BP = ND * DW;
	localparam int PRW = AW + BW;
	localparam int XW = AW + BP;

	logic [AW-1:0]  a_s [ND];
	logic [BP-1:0]  b_s [ND];
	logic [PRW-1:0] acc_s [ND];
	logic [BP-1:0]  b_pad;

	assign b_pad = BP'(b);

	for (genvar k = 0; k < ND; k++) begin : g_st
		logic [AW-1:0]    a_in;
		logic [BP-1:0]    b_in;
		logic [PRW-1:0]   acc_in;
		logic [AW+DW-1:0] pp;
		logic [XW-1:0]    term;

		if (k == 0) begin : g_first
			assign a_in = a;
			assign b_in = b_pad;
			assign acc_in = '0;
		end else begin : g_next
			assign a_in = a_s[k-1];
			assign b_in = b_s[k-1];
			assign acc_in = acc_s[k-1];
		end

		assign pp = {{DW{1'b0}}, a_in} * {{AW{1'b0}}, b_in[k*DW +: DW]};
		assign term = XW'(pp) << (k * DW);

		always_ff @(posedge clk) begin
			if (en) begin
				a_s[k] <= a_in;
				b_s[k] <= b_in;
				acc_s[k] <= acc_in + term[PRW-1:0];
			end
		end
	end

	assign p = acc_s[ND-1];

endmodule

/* design/ccx_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
module ccx_sqrt #(
	parameter int XW = 8
) (
	input  logic            clk,
	input  logic            en,
	input  logic [XW-1:0]   x,
	output logic [XW/2-1:0] root
);

	localparam int NS = XW / 2;
	localparam int RMW = NS + 2;

	logic [RMW-1:0] rem_s [NS];
	logic [NS-1:0]  root_s [NS];
	logic [XW-1:0]  x_s [NS];

	for (genvar k = 0; k < NS; k++) begin : g_st
		logic [RMW-1:0] rem_in;
		logic [NS-1:0]  root_in;
		logic [XW-1:0]  x_in;
		logic [RMW+1:0] rem2;
		logic [RMW+1:0] trial;
		logic           ge;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign root_in = '0;
			assign x_in = x;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign x_in = x_s[k-1];
		end

		assign rem2 = {rem_in, x_in[XW-1:XW-2]};
		assign trial = (RMW+2)'({root_in, 2'b01});
		assign ge = rem2 >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? RMW'(rem2 - trial) : RMW'(rem2);
				root_s[k] <= {root_in[NS-2:0], ge};
				x_s[k] <= {x_in[XW-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[NS-1];

endmodule

/* design/ccx_div.sv */
// Pipelined restoring divider, one quotient bit per stage, rounded half away from zero.
module ccx_div #(
	parameter int NW = 8,
	parameter int DVW = 8
) (
	input  logic           clk,
	input  logic           en,
	input  logic [NW-1:0]  num,
	input  logic [DVW-1:0] den,
	output logic [NW:0]    quo
);

	logic [DVW-1:0] rem_s [NW];
	logic [NW-1:0]  nq_s [NW];
	logic [DVW-1:0] den_s [NW];
	logic [NW:0]    quo_q;

	for (genvar k = 0; k < NW; k++) begin : g_st
		logic [DVW-1:0] rem_in;
		logic [NW-1:0]  nq_in;
		logic [DVW-1:0] den_in;
		logic [DVW:0]   rem2;
		logic           ge;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign nq_in = num;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign nq_in = nq_s[k-1];
			assign den_in = den_s[k-1];
		end

		assign rem2 = {rem_in, nq_in[NW-1]};
		assign ge = rem2 >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DVW'(rem2 - {1'b0, den_in}) : DVW'(rem2);
				nq_s[k] <= {nq_in[NW-2:0], ge};
				den_s[k] <= den_in;
			end
		end
	end

	// Round up when twice the remainder reaches the divisor.
	always_ff @(posedge clk) begin
		if (en) begin
			quo_q <= {1'b0, nq_s[NW-1]}
				+ (NW+1)'({rem_s[NW-1], 1'b0} >= {1'b0, den_s[NW-1]});
		end
	end

	assign quo = quo_q;

endmodule

/* design/ccx_chk.sv */
// Port checker for the circle intersection pipeline, bound to the top level.
module ccx_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input ccx_pkg::item_t   item,
	input logic             result_valid,
	input logic             result_stall,
	input ccx_pkg::result_t result
);

	import ccx_pkg::*;

	// A held result stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result transfer dropped while stalled");

	// A held result does not change.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result changed while stalled");

	// The input side stalls exactly when a finished result is held back.
	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid || !item_valid |-> item_stall == (result_valid && result_stall))
		else $error("input stall does not follow the output stall");

	// Points are zero unless the circles cross or touch in two points; never contained and coincident.
	a_no_points: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.fully_contained || result.coincident || !result.touching)
		|-> result.point1_x == '0 && result.point1_y == '0
			&& result.point2_x == '0 && result.point2_y == '0
			&& !(result.fully_contained && result.coincident))
		else $error("points given for a case without intersection points");

endmodule

bind circle_circle_intersection ccx_chk u_ccx_chk (
	.clk(clk),
	.arst_n(arst_n),
	.item_valid(item_valid),
	.item_stall(item_stall),
	.item(item),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result(result)
);

/* verif/circle_circle_intersection_tb.sv */
// Self-checking testbench for the circle-circle intersection pipeline.
module circle_circle_intersection_tb;
	import ccx_pkg::*;

	// Exact integer arithmetic wide enough for every intermediate product.
	typedef logic signed [255:0] wide_t;

	localparam int RANDOM_ITEMS = 1600;
	localparam int QUIET_TAIL   = 200;    // no idling in the last transfers
	localparam int HOLD_AT      = 700;    // transfer count that triggers the long hold
	localparam int HOLD_CYCLES  = 400;    // longer than the pipeline latency
	localparam int DRAIN_CYCLES = 250;
	localparam int ONE          = 65536;  // 1.0 in Q16.16

	typedef struct {
		item_t   it;
		bit      typed;
		result_t res;
	} stim_row_t;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	result_t   expected_results[$];
	stim_row_t stim_rows[$];
	int        mismatches;
	int        items_sent;
	bit        stimulus_done;

	circle_circle_intersection u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Safety net: the slowest correct run is far below this.
	initial begin
		#4000000;
		$display("end of test: mismatches");
		$finish;
	end

	// Floor of the square root, found one bit at a time. The argument is
	// below 2^140, so the root fits in 71 bits.
	function automatic wide_t floor_sqrt(wide_t x);
		wide_t root;
		wide_t trial;
		root = 0;
		for (int k = 71; k >= 0; k--) begin
			trial = root | (wide_t'(1) <<< k);
			if (trial * trial <= x)
				root = trial;
		end
		return root;
	endfunction

	// Quotient rounded to nearest with ties away from zero; the magnitude
	// is capped at 2^62 before the sign is put back.
	function automatic wide_t div_round(wide_t num, wide_t den);
		wide_t mag;
		wide_t quo;
		wide_t rem;
		mag = (num < 0) ? -num : num;
		quo = mag / den;
		rem = mag % den;
		if (2 * rem >= den)
			quo = quo + 1;
		if (quo > (wide_t'(1) <<< 62))
			quo = wide_t'(1) <<< 62;
		return (num < 0) ? -quo : quo;
	endfunction

	// Adds an offset to a centre coordinate and clamps to the port range.
	function automatic logic signed [CW-1:0] offset_sat(wide_t base, wide_t offs);
		wide_t sum;
		wide_t hi;
		hi  = (wide_t'(1) <<< (CW - 1)) - 1;
		sum = base + offs;
		if (sum > hi)
			sum = hi;
		if (sum < -hi - 1)
			sum = -hi - 1;
		return sum[CW-1:0];
	endfunction

	// Computes the intersection result of one circle pair.
	function automatic result_t intersect_circles(item_t it);
		result_t r;
		wide_t x1, y1, x2, y2, r1, r2;
		wide_t vx, vy, vv, r1sq, r2sq, dr, rs, n, q, s, dd;
		x1 = it.first_center_x;
		y1 = it.first_center_y;
		x2 = it.second_center_x;
		y2 = it.second_center_y;
		r1 = {1'b0, it.first_radius};
		r2 = {1'b0, it.second_radius};
		r  = '0;
		vx = x2 - x1;
		vy = y2 - y1;
		vv = vx * vx + vy * vy;
		r1sq = r1 * r1;
		r2sq = r2 * r2;
		dr = r1 - r2;
		rs = r1 + r2;
		if (vv < dr * dr) begin
			// Smaller circle strictly inside the larger one.
			r.touching        = 1'b1;
			r.fully_contained = 1'b1;
		end else if (vv > rs * rs) begin
			// Too far apart: everything stays zero.
		end else if (vv == 0) begin
			// Same centre and same radius.
			r.touching   = 1'b1;
			r.coincident = 1'b1;
		end else begin
			n  = r1sq - r2sq + vv;
			q  = 4 * r1sq * vv - n * n;
			s  = (q > 0) ? floor_sqrt(q) : wide_t'(0);
			dd = 2 * vv;
			r.touching = 1'b1;
			r.point1_x = offset_sat(x1, div_round(vx * n - vy * s, dd));
			r.point1_y = offset_sat(y1, div_round(vy * n + vx * s, dd));
			r.point2_x = offset_sat(x1, div_round(vx * n + vy * s, dd));
			r.point2_y = offset_sat(y1, div_round(vy * n - vx * s, dd));
		end
		return r;
	endfunction

	function automatic item_t make_pair(longint ax, longint ay, longint ar,
			longint bx, longint by, longint br);
		item_t it;
		it.first_center_x  = ax[CW-1:0];
		it.first_center_y  = ay[CW-1:0];
		it.first_radius    = ar[RW-1:0];
		it.second_center_x = bx[CW-1:0];
		it.second_center_y = by[CW-1:0];
		it.second_radius   = br[RW-1:0];
		return it;
	endfunction

	function automatic result_t make_result(bit t, bit f, bit c,
			longint p1x, longint p1y, longint p2x, longint p2y);
		result_t r;
		r.touching        = t;
		r.fully_contained = f;
		r.coincident      = c;
		r.point1_x        = p1x[CW-1:0];
		r.point1_y        = p1y[CW-1:0];
		r.point2_x        = p2x[CW-1:0];
		r.point2_y        = p2y[CW-1:0];
		return r;
	endfunction

	task automatic add_row(item_t it, bit typed, result_t res);
		stim_row_t row;
		row.it    = it;
		row.typed = typed;
		row.res   = res;
		stim_rows.push_back(row);
	endtask

	// Random pair. Most pairs are drawn at one scale with the second centre
	// within ar + br + 2 of the first on each axis; the rest are raw noise over
	// the full field ranges, which also toggles every input bit.
	function automatic item_t random_pair();
		int     sc;
		longint mask, ax, ay, ar, br, reach;
		if ($urandom_range(0, 9) < 2)
			return make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		sc   = $urandom_range(2, 30);
		mask = (longint'(1) << sc) - 1;
		ar   = $urandom & mask;
		br   = $urandom & mask;
		ax   = $signed($urandom);
		ay   = $signed($urandom);
		if ($urandom_range(0, 3) == 0) begin
			ax = ax >>> $urandom_range(0, 31);
			ay = ay >>> $urandom_range(0, 31);
		end
		reach = ar + br + 2;
		return make_pair(ax, ay, ar,
			ax + longint'($urandom_range(0, 2 * reach)) - reach,
			ay + longint'($urandom_range(0, 2 * reach)) - reach,
			br);
	endfunction

	// Builds the directed rows. Results are typed in where they are obvious.
	task automatic load_directed_rows();
		result_t none;
		longint  max_c, min_c, max_r;
		none  = '0;
		max_c = 64'sh7fffffff;
		min_c = -64'sh80000000;
		max_r = 64'sh7fffffff;
		// Far apart: no contact.
		add_row(make_pair(0, 0, ONE, 10 * ONE, 0, ONE), 1'b1, none);
		// Small circle inside a large one.
		add_row(make_pair(0, 0, 10 * ONE, ONE, ONE, ONE), 1'b1,
			make_result(1, 1, 0, 0, 0, 0, 0));
		// Coincident equal circles, also at the field extremes.
		add_row(make_pair(3 * ONE, -2 * ONE, ONE, 3 * ONE, -2 * ONE, ONE), 1'b1,
			make_result(1, 0, 1, 0, 0, 0, 0));
		add_row(make_pair(max_c, min_c, max_r, max_c, min_c, max_r), 1'b1,
			make_result(1, 0, 1, 0, 0, 0, 0));
		add_row(make_pair(min_c, max_c, 0, min_c, max_c, 0), 1'b1,
			make_result(1, 0, 1, 0, 0, 0, 0));
		// Outer tangency: both points land on (1, 0).
		add_row(make_pair(0, 0, ONE, 2 * ONE, 0, ONE), 1'b1,
			make_result(1, 0, 0, ONE, 0, ONE, 0));
		// Inner tangency, just past it, and a plain crossing.
		add_row(make_pair(0, 0, 2 * ONE, ONE, 0, ONE), 1'b0, none);
		add_row(make_pair(0, 0, 2 * ONE, ONE - 1, 0, ONE), 1'b0, none);
		add_row(make_pair(0, 0, ONE, ONE, ONE, ONE), 1'b0, none);
		// Same centre, different radii: containment.
		add_row(make_pair(5, 5, 7, 5, 5, 3), 1'b1, make_result(1, 1, 0, 0, 0, 0, 0));
		// Tiny values with a small square root argument.
		add_row(make_pair(0, 0, 1, 1, 1, 1), 1'b0, none);
		add_row(make_pair(0, 0, 3, 5, 1, 3), 1'b0, none);
		// Centres at the field extremes with large radii; one pair has points that saturate.
		add_row(make_pair(max_c, max_c, max_r, min_c, min_c, max_r), 1'b0, none);
		add_row(make_pair(min_c, max_c, max_r, max_c, min_c, max_r), 1'b0, none);
		add_row(make_pair(max_c, max_c, max_r, max_c - 1, max_c, max_r), 1'b0, none);
		add_row(make_pair(min_c, min_c, max_r, min_c, min_c + ONE, 0), 1'b0, none);
		// Zero radii: two points, apart and together.
		add_row(make_pair(1, 2, 0, 3, 4, 0), 1'b1, none);
		add_row(make_pair(1, 2, 0, 1, 2, 0), 1'b1, make_result(1, 0, 1, 0, 0, 0, 0));
	endtask

	// Sender. The payload is driven at the rising edge; a transfer is
	// recognized from the values held just before that edge, sampled at the
	// falling edge, so no check races the design's own updates.
	task automatic send_item(item_t it, bit typed, result_t res, bit allow_idle);
		bit taken;
		if (allow_idle && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = item_valid && !item_stall;
			@(posedge clk);
		end
		expected_results.push_back(typed ? res : intersect_circles(it));
		items_sent++;
	endtask

	initial begin
		result_t none;
		none          = '0;
		arst_n        = 1'b0;
		item_valid    = 1'b0;
		item          = '0;
		mismatches    = 0;
		items_sent    = 0;
		stimulus_done = 1'b0;
		load_directed_rows();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (stim_rows[i])
			send_item(stim_rows[i].it, stim_rows[i].typed, stim_rows[i].res, 1'b1);
		for (int i = 0; i < RANDOM_ITEMS; i++)
			send_item(random_pair(), 1'b0, none, i < RANDOM_ITEMS - QUIET_TAIL);
		item_valid    <= 1'b0;
		stimulus_done = 1'b1;
	end

	// Receiver stall pattern: random bursts, one long hold-off once the sender
	// has moved HOLD_AT transfers so that the pipeline fills and stalls the
	// input, and no stalls at all near the end.
	initial begin
		bit held;
		held         = 1'b0;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && items_sent >= HOLD_AT) begin
				held = 1'b1;
				result_stall <= 1'b1;
				for (int c = 0; c < HOLD_CYCLES; c++)
					@(posedge clk);
				result_stall <= 1'b0;
			end else if (items_sent < stim_rows.size() + RANDOM_ITEMS - QUIET_TAIL
					&& $urandom_range(0, 7) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	task automatic report_field(string name, longint want, longint got);
		mismatches++;
		$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
	endtask

	// Result checker: each transfer is compared against the oldest expectation.
	initial begin
		result_t want;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: result transfer with nothing expected, actual %p",
						$time, result);
				end else begin
					want = expected_results.pop_front();
					if (result.touching !== want.touching)
						report_field("touching", want.touching, result.touching);
					if (result.fully_contained !== want.fully_contained)
						report_field("fully_contained", want.fully_contained,
							result.fully_contained);
					if (result.coincident !== want.coincident)
						report_field("coincident", want.coincident, result.coincident);
					if (result.point1_x !== want.point1_x)
						report_field("point1_x", want.point1_x, result.point1_x);
					if (result.point1_y !== want.point1_y)
						report_field("point1_y", want.point1_y, result.point1_y);
					if (result.point2_x !== want.point2_x)
						report_field("point2_x", want.point2_x, result.point2_x);
					if (result.point2_y !== want.point2_y)
						report_field("point2_y", want.point2_y, result.point2_y);
				end
			end
		end
	end

	// End of run: drain every expectation, then give the pipeline its
	// latency again to catch any stray extra transfer.
	initial begin
		wait (stimulus_done);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
